FILE: design/cms_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CAN message segmenter.
// Used by cms_front, cms_queue, cms_back and the top level.
package cms_pkg;

    // Default frame size in bytes, index byte included
    localparam int FRAME_BYTES_DEF = 8;
    // Frame bytes visible on the output port
    localparam int OUT_BYTES       = 8;
    // Width of the frame index inside the index byte
    localparam int IDX_W           = 6;
    // Descriptor queue depth between front and back
    localparam int QUEUE_DEPTH     = 2;
    // Flag ORed into the index byte of the final segmented frame
    localparam logic [7:0] LAST_FLAG = 8'h80;

    typedef logic [7:0] t_byte;

    // One classified payload beat, handed from front to back
    typedef struct packed {
        t_byte            data;     // payload byte
        logic [2:0]       lane;     // output lane the byte lands in
        logic             lane_en;  // lane lies inside the visible frame
        logic             first;    // first byte of a frame: start from a clear buffer
        logic             done;     // frame completes with this byte
        logic             seg;      // message is split into indexed frames
        logic             last;     // final frame of the message
        logic [IDX_W-1:0] idx;      // frame index for the index byte
        logic [3:0]       flen;     // frame length, low four bits
        logic [1:0]       seq;      // message sequence number
    } t_desc;

endpackage

FILE: design/cms_front.sv
`timescale 1ns / 1ps
// Front end: accepts payload beats, tracks message and frame position,
// and classifies each beat into a descriptor. Depends on cms_pkg.
module cms_front #(
    parameter int FRAME_BYTES = cms_pkg::FRAME_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic [7:0]      i_message_length,
    input  logic            i_full,
    output logic            o_stall,
    output logic            o_push,
    output cms_pkg::t_desc  o_desc
);

    localparam int SW = $clog2(FRAME_BYTES);
    localparam logic [7:0]    FB8      = 8'(FRAME_BYTES);
    localparam logic [SW-1:0] FILL_MAX = SW'(FRAME_BYTES - 1);

    logic [1:0]                 r_seq,   n_seq;
    logic [7:0]                 r_len,   n_len;
    logic [7:0]                 r_taken, n_taken;
    logic [SW-1:0]              r_fill,  n_fill;
    logic [cms_pkg::IDX_W-1:0]  r_idx,   n_idx;

    logic                       acc;
    logic                       start;
    logic [7:0]                 len_eff;
    logic [7:0]                 taken_eff;
    logic [7:0]                 taken_nx;
    logic [SW-1:0]              fill_eff;
    logic [SW-1:0]              fill_nx;
    logic [cms_pkg::IDX_W-1:0]  idx_eff;
    logic [1:0]                 seq_eff;
    logic                       plain;
    logic [SW-1:0]              slot;
    logic                       seg_end;
    logic                       seg_full;
    logic [7:0]                 seg_len;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;
    assign o_push  = acc;

    // Latch length and advance sequence at the first beat of a message
    always_comb begin
        start     = (r_taken == 8'd0);
        len_eff   = start ? ((i_message_length == 8'd0) ? 8'd1 : i_message_length) : r_len;
        seq_eff   = start ? r_seq + 2'd1 : r_seq;
        taken_eff = start ? 8'd0 : r_taken;
        fill_eff  = start ? '0 : r_fill;
        idx_eff   = start ? '0 : r_idx;
        taken_nx  = taken_eff + 8'd1;
        fill_nx   = fill_eff + SW'(1);
        plain     = (len_eff <= FB8);
        seg_end   = (taken_nx >= len_eff);
        seg_full  = (fill_nx == FILL_MAX);
        seg_len   = 8'(fill_nx) + 8'd1;
        slot      = plain ? taken_eff[SW-1:0] : fill_eff + SW'(1);
    end

    // Classify the beat
    always_comb begin
        o_desc.data    = i_data_byte;
        o_desc.lane    = 3'(slot);
        o_desc.lane_en = (8'(slot) < 8'(cms_pkg::OUT_BYTES));
        o_desc.seq     = seq_eff;
        o_desc.idx     = idx_eff;
        o_desc.seg     = !plain;
        if (plain) begin
            o_desc.first = (taken_eff == 8'd0);
            o_desc.done  = seg_end;
            o_desc.last  = 1'b1;
            o_desc.flen  = len_eff[3:0];
        end else begin
            o_desc.first = (fill_eff == '0);
            o_desc.done  = seg_end || seg_full;
            o_desc.last  = seg_end;
            o_desc.flen  = seg_end ? seg_len[3:0] : FB8[3:0];
        end
    end

    // Advance message position
    always_comb begin
        n_seq   = r_seq;
        n_len   = r_len;
        n_taken = r_taken;
        n_fill  = r_fill;
        n_idx   = r_idx;
        if (acc) begin
            n_seq   = seq_eff;
            n_len   = len_eff;
            n_taken = seg_end ? 8'd0 : taken_nx;
            if (plain || seg_end) begin
                n_fill = '0;
                n_idx  = '0;
            end else if (seg_full) begin
                n_fill = '0;
                n_idx  = idx_eff + cms_pkg::IDX_W'(1);
            end else begin
                n_fill = fill_nx;
                n_idx  = idx_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= '0;
            r_len   <= '0;
            r_taken <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
        end else begin
            r_seq   <= n_seq;
            r_len   <= n_len;
            r_taken <= n_taken;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
        end
    end

endmodule

FILE: design/cms_queue.sv
`timescale 1ns / 1ps
// Short descriptor queue between front and back.
// Depends on cms_pkg for the descriptor type and depth.
module cms_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cms_pkg::t_desc  i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output cms_pkg::t_desc  o_desc
);

    localparam int DEPTH = cms_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    cms_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store pushed descriptors
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

FILE: design/cms_back.sv
`timescale 1ns / 1ps
// Back end: assembles frame bytes from descriptors and holds the finished
// frame in the output register. Depends on cms_pkg.
module cms_back #(
    parameter int FRAME_BYTES = cms_pkg::FRAME_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  cms_pkg::t_desc  i_q_desc,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output cms_pkg::t_byte  o_bytes [cms_pkg::OUT_BYTES],
    output logic [3:0]      o_frame_length,
    output logic            o_segmented,
    output logic [1:0]      o_sequence_number,
    output logic            o_last_frame
);

    localparam int NB = cms_pkg::OUT_BYTES;
    localparam logic [7:0] FB8 = 8'(FRAME_BYTES);

    cms_pkg::t_byte r_buf [NB];
    cms_pkg::t_byte merged [NB];
    cms_pkg::t_byte r_out [NB];
    logic           r_valid;
    logic [3:0]     r_flen;
    logic           r_seg;
    logic [1:0]     r_seq;
    logic           r_last;
    logic           out_free;
    logic           emit;

    assign out_free = !r_valid || !i_stall;
    assign o_pop    = i_q_valid && (!i_q_desc.done || out_free);
    assign emit     = o_pop && i_q_desc.done;

    // Merge the beat (clear at frame start) and set any index byte
    always_comb begin
        for (int j = 0; j < NB; j++) begin
            merged[j] = i_q_desc.first ? 8'd0 : r_buf[j];
            if (i_q_desc.lane_en && (i_q_desc.lane == 3'(j))) begin
                merged[j] = i_q_desc.data;
            end
        end
        if (i_q_desc.done && i_q_desc.seg) begin
            merged[0] = 8'(i_q_desc.idx) | (i_q_desc.last ? cms_pkg::LAST_FLAG : 8'd0);
        end
    end

    // Hold partial frame; clear it once the frame leaves
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int j = 0; j < NB; j++) begin
                r_buf[j] <= emit ? 8'd0 : merged[j];
            end
        end
    end

    // Load the output register on a finished frame
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out  <= merged;
            r_flen <= i_q_desc.flen;
            r_seg  <= i_q_desc.seg;
            r_seq  <= i_q_desc.seq;
            r_last <= i_q_desc.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid           = r_valid;
    assign o_bytes           = r_out;
    assign o_frame_length    = r_flen;
    assign o_segmented       = r_seg;
    assign o_sequence_number = r_seq;
    assign o_last_frame      = r_last;

`ifndef NO_ASSERTIONS
    // A segmented frame that is not the last one is always full
    a_full_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_seg && !r_last |-> r_flen == FB8[3:0])
        else $error("segmented middle frame is not full");

    // A plain frame is always the last frame of its message
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_seg |-> r_last)
        else $error("plain frame without last flag");

    // The index byte carries the last flag and a clear bit six
    a_idx_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_seg |-> (r_out[0][7] == r_last) && !r_out[0][6])
        else $error("index byte does not match last flag");

    // A finished frame is never overwritten while stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |-> !emit)
        else $error("frame loaded over a stalled frame");
`endif

endmodule

FILE: design/can_message_segmenter.sv
`timescale 1ns / 1ps
// Takes one payload byte per beat and emits CAN-style frames: a message of up
// to FRAME_BYTES bytes leaves as one plain frame, a longer one as indexed
// frames of an index byte and up to FRAME_BYTES-1 data bytes, the last marked
// with bit 7 of its index byte. Unless a finished frame waits on a stalled
// output, the block sustains one byte per clock: the front end classifies
// each byte in the cycle it is accepted, a two-entry queue decouples it from
// the back end, and the back end merges one byte per clock into the frame
// buffer. A frame enters the output register once its final byte leaves the
// queue. While a finished frame waits on a stalled output, bytes of the
// next frame keep flowing; only that frame's final byte waits, the queue then
// takes one more beat and the input stalls until the output is taken.
// Depends on cms_pkg, cms_front, cms_queue and cms_back.
module can_message_segmenter #(
    parameter int FRAME_BYTES = cms_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_message_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte_0,
    output logic [7:0]  o_frame_byte_1,
    output logic [7:0]  o_frame_byte_2,
    output logic [7:0]  o_frame_byte_3,
    output logic [7:0]  o_frame_byte_4,
    output logic [7:0]  o_frame_byte_5,
    output logic [7:0]  o_frame_byte_6,
    output logic [7:0]  o_frame_byte_7,
    output logic [3:0]  o_frame_length,
    output logic        o_segmented,
    output logic [1:0]  o_sequence_number,
    output logic        o_last_frame
);

    cms_pkg::t_desc front_desc;
    cms_pkg::t_desc q_desc;
    cms_pkg::t_byte bytes [cms_pkg::OUT_BYTES];
    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;

    // Classify incoming beats
    cms_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .i_full           (q_full),
        .o_stall          (o_stall),
        .o_push           (push),
        .o_desc           (front_desc)
    );

    // Decouple front and back
    cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    // Assemble and present frames
    cms_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_desc          (q_desc),
        .o_pop             (pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_bytes           (bytes),
        .o_frame_length    (o_frame_length),
        .o_segmented       (o_segmented),
        .o_sequence_number (o_sequence_number),
        .o_last_frame      (o_last_frame)
    );

    assign o_frame_byte_0 = bytes[0];
    assign o_frame_byte_1 = bytes[1];
    assign o_frame_byte_2 = bytes[2];
    assign o_frame_byte_3 = bytes[3];
    assign o_frame_byte_4 = bytes[4];
    assign o_frame_byte_5 = bytes[5];
    assign o_frame_byte_6 = bytes[6];
    assign o_frame_byte_7 = bytes[7];

endmodule

FILE: dv/can_message_segmenter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for can_message_segmenter: drives byte-serial messages
// and checks every frame against an in-bench segmentation predictor.
// Depends on cms_pkg and the can_message_segmenter RTL.
module can_message_segmenter_tb;

    localparam int FB          = cms_pkg::FRAME_BYTES_DEF;
    localparam int RAND_BYTES  = 700;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 150000;

    // One frame as seen on the output ports
    typedef struct packed {
        cms_pkg::t_byte [cms_pkg::OUT_BYTES-1:0] bytes;
        logic [3:0]                              flen;
        logic                                    seg;
        logic [1:0]                              seq;
        logic                                    last;
    } t_frame;

    // Segmentation predictor plus the queue of frames still owed by the block
    class segment_checker;
        logic [1:0]     seq_num;
        int             msg_len;
        int             taken;
        int             fill;
        logic [5:0]     idx;
        cms_pkg::t_byte asm_bytes[FB];
        t_frame         frames_due[$];
        int             errors;
        int             frames_seen;
        int             segs_seen;

        function new();
            seq_num = '0;
            msg_len = 0;
            taken = 0;
            fill = 0;
            idx = '0;
            foreach (asm_bytes[j]) asm_bytes[j] = '0;
            errors = 0;
            frames_seen = 0;
            segs_seen = 0;
        endfunction

        // Queue the frame under assembly and clear the assembly buffer
        function void push_frame(int flen, logic seg, logic last);
            t_frame f;
            f = '0;
            for (int j = 0; j < cms_pkg::OUT_BYTES; j++)
                f.bytes[j] = (j < FB && j < flen) ? asm_bytes[j] : 8'h00;
            f.flen = flen[3:0];
            f.seg  = seg;
            f.seq  = seq_num;
            f.last = last;
            frames_due.push_back(f);
            foreach (asm_bytes[j]) asm_bytes[j] = '0;
        endfunction

        // Advance the predictor by one accepted byte beat
        function void take_byte(cms_pkg::t_byte d, cms_pkg::t_byte l);
            if (taken == 0) begin
                // First byte: latch length (zero counts as one), bump sequence
                msg_len = (l == 8'd0) ? 1 : int'(l);
                seq_num = seq_num + 2'd1;
                idx = '0;
                fill = 0;
                foreach (asm_bytes[j]) asm_bytes[j] = '0;
            end
            if (msg_len <= FB) begin
                // Plain frame: bytes land at their own offset
                if (taken < FB) asm_bytes[taken] = d;
                taken++;
                if (taken >= msg_len) begin
                    push_frame(msg_len, 1'b0, 1'b1);
                    taken = 0;
                end
            end else begin
                // Segmented: byte 0 is reserved for the index
                if (fill < FB - 1) asm_bytes[1 + fill] = d;
                fill++;
                taken++;
                if (taken >= msg_len) begin
                    asm_bytes[0] = {2'b00, idx} | cms_pkg::LAST_FLAG;
                    push_frame(fill + 1, 1'b1, 1'b1);
                    taken = 0;
                    fill = 0;
                    idx = '0;
                end else if (fill >= FB - 1) begin
                    asm_bytes[0] = {2'b00, idx};
                    push_frame(FB, 1'b1, 1'b0);
                    idx = idx + 6'd1;
                    fill = 0;
                end
            end
        endfunction

        // Compare one output frame with the oldest expected one
        function void match_frame(t_frame got);
            t_frame want;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected frame %h, none expected", $time, got);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            frames_seen++;
            if (want.seg) segs_seen++;
            for (int j = 0; j < cms_pkg::OUT_BYTES; j++) begin
                if (got.bytes[j] !== want.bytes[j]) begin
                    $display("%0t: frame_byte_%0d expected %02h actual %02h",
                             $time, j, want.bytes[j], got.bytes[j]);
                    errors++;
                end
            end
            if (got.flen !== want.flen) begin
                $display("%0t: frame_length expected %0d actual %0d",
                         $time, want.flen, got.flen);
                errors++;
            end
            if (got.seg !== want.seg) begin
                $display("%0t: segmented expected %b actual %b", $time, want.seg, got.seg);
                errors++;
            end
            if (got.seq !== want.seq) begin
                $display("%0t: sequence_number expected %0d actual %0d",
                         $time, want.seq, got.seq);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_frame expected %b actual %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic [7:0]  i_message_length = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_frame_byte_0, o_frame_byte_1, o_frame_byte_2, o_frame_byte_3;
    logic [7:0]  o_frame_byte_4, o_frame_byte_5, o_frame_byte_6, o_frame_byte_7;
    logic [3:0]  o_frame_length;
    logic        o_segmented;
    logic [1:0]  o_sequence_number;
    logic        o_last_frame;

    segment_checker sb = new();
    bit quiet = 1'b0;      // no idling on either side while set
    bit hold_req = 1'b0;   // ask the receiver for a long hold-off
    int bytes_sent = 0;
    int msgs_sent = 0;
    int cycles = 0;

    can_message_segmenter i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_message_length  (i_message_length),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_byte_0    (o_frame_byte_0),
        .o_frame_byte_1    (o_frame_byte_1),
        .o_frame_byte_2    (o_frame_byte_2),
        .o_frame_byte_3    (o_frame_byte_3),
        .o_frame_byte_4    (o_frame_byte_4),
        .o_frame_byte_5    (o_frame_byte_5),
        .o_frame_byte_6    (o_frame_byte_6),
        .o_frame_byte_7    (o_frame_byte_7),
        .o_frame_length    (o_frame_length),
        .o_segmented       (o_segmented),
        .o_sequence_number (o_sequence_number),
        .o_last_frame      (o_last_frame)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d frames outstanding",
                     cycles, sb.frames_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check every frame beat taken from the block
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.match_frame({o_frame_byte_7, o_frame_byte_6, o_frame_byte_5, o_frame_byte_4,
                            o_frame_byte_3, o_frame_byte_2, o_frame_byte_1, o_frame_byte_0,
                            o_frame_length, o_segmented, o_sequence_number, o_last_frame});
        end
    end

    // Receiver: random stall, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_stall <= !quiet && ($urandom_range(99) < 20);
        end
    end

    // Offer one byte beat and hold it until accepted
    task automatic send_byte(input cms_pkg::t_byte d, input cms_pkg::t_byte l);
        i_valid <= 1'b1;
        i_data_byte <= d;
        i_message_length <= l;
        do @(posedge i_clk); while (o_stall);
        sb.take_byte(d, l);
        bytes_sent++;
    endtask

    // Drop valid for a random gap now and then
    task automatic maybe_idle();
        if (!quiet && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Send a whole message; bytes after the first carry a random length
    task automatic send_message(input cms_pkg::t_byte len, input bit gaps);
        int n;
        n = (len == 8'd0) ? 1 : int'(len);
        for (int k = 0; k < n; k++) begin
            send_byte(cms_pkg::t_byte'($urandom_range(255)),
                      (k == 0) ? len : cms_pkg::t_byte'($urandom_range(255)));
            if (gaps) maybe_idle();
        end
        msgs_sent++;
    endtask

    // Stop offering until every expected frame has come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.frames_due.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int rand_start;
        int r;
        cms_pkg::t_byte len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero length, single byte, full plain frame, shortest split
        send_byte(8'h00, 8'd0);
        msgs_sent++;
        maybe_idle();
        send_byte(8'hFF, 8'd1);
        msgs_sent++;
        maybe_idle();
        send_message(8'd8, 1'b1);
        send_message(8'd9, 1'b1);
        drain();

        // Hold the receiver off while a longest message streams in
        hold_req = 1'b1;
        send_message(8'd255, 1'b0);
        drain();

        // Random messages, mostly short, with a stretch of no idling
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES) begin
            quiet = (bytes_sent - rand_start >= 400) && (bytes_sent - rand_start < 600);
            r = $urandom_range(99);
            if (r < 50)      len = cms_pkg::t_byte'($urandom_range(1, 8));
            else if (r < 78) len = cms_pkg::t_byte'($urandom_range(9, 40));
            else if (r < 88) len = cms_pkg::t_byte'(7 * $urandom_range(2, 10));
            else if (r < 95) len = cms_pkg::t_byte'($urandom_range(0, 1) ? 0 : 9);
            else             len = cms_pkg::t_byte'($urandom_range(41, 255));
            send_message(len, 1'b1);
        end
        quiet = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);

        if (sb.frames_due.size() != 0) begin
            $display("%0t: %0d expected frames never arrived", $time, sb.frames_due.size());
            sb.errors++;
        end
        $display("Streamed %0d bytes in %0d messages (lengths 0..255, one long output hold-off)",
                 bytes_sent, msgs_sent);
        $display("Compared %0d frames, %0d of them segmented, %0d mismatches",
                 sb.frames_seen, sb.segs_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
